// File: rtl/core/upc_pkg.sv
// ----------------------------------------------------------------------------
// upc_pkg
// Shared constants for the unix path canonicaliser: store sizes, derived
// widths, operation codes and path characters.
// ----------------------------------------------------------------------------
package upc_pkg;

    localparam int PATH_BYTES   = 512;
    localparam int MAX_SEGMENTS = 256;

    localparam int LEN_W      = $clog2(PATH_BYTES + 1);
    localparam int SEGLEN_W   = $clog2(PATH_BYTES + 2);
    localparam int ADDR_W     = $clog2(PATH_BYTES);
    localparam int BANK_AW    = ADDR_W - 1;
    localparam int BANK_DEPTH = PATH_BYTES / 2;
    localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_AW     = $clog2(MAX_SEGMENTS);

    localparam int INDEX_W  = 9;
    localparam int LENGTH_W = 10;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

endpackage

// File: rtl/core/unix_path_canonicalizer_core.sv
// ----------------------------------------------------------------------------
// unix_path_canonicalizer_core
// Streams a path one byte per transfer and builds its canonical absolute
// form in a banked byte store, with segment starts on a stack memory.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+----------------------
//   input   | in        | i_in_valid / o_in_ready     | op, ch, last, index
//   result  | out       | o_out_valid / i_out_ready   | done_res, length,
//           |           |                             | byte_out, overflow
//
// one transfer per cycle while the output is not stalled; each result passes
// through the store read stage, then the output register
// the byte store is split into even and odd banks so a '/' and a character
// land in the same cycle; a '..' pop refills the top-of-stack register from
// the stack memory in the following cycle
// synchronous active-low reset clears control state only; the memories need
// no clearing pass
// a stalled output holds one result and the read stage takes one more
// ----------------------------------------------------------------------------
module unix_path_canonicalizer_core
    import upc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [7:0]          i_ch,
    input  logic                i_last,
    input  logic [INDEX_W-1:0]  i_index,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_done_res,
    output logic [LENGTH_W-1:0] o_length,
    output logic [7:0]          o_byte_out,
    output logic                o_overflow
);

    localparam int SUM_W = LEN_W + 2;

    // architectural state
    logic [LEN_W-1:0]    r_path_len, n_path_len;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SEGLEN_W-1:0] r_seg_len, n_seg_len;
    logic [1:0]          r_flags, n_flags;
    logic                r_ovf, n_ovf;
    logic                r_finished, n_finished;
    logic [LEN_W-1:0]    r_open_start, n_open_start;
    logic [LEN_W-1:0]    r_top_start, n_top_start;
    logic                r_rd_pend, n_rd_pend;

    // memories
    logic [7:0]       r_bank_even [BANK_DEPTH];
    logic [7:0]       r_bank_odd  [BANK_DEPTH];
    logic [7:0]       r_bank_even_q, r_bank_odd_q;
    logic [LEN_W-1:0] r_seg_mem [MAX_SEGMENTS];
    logic [LEN_W-1:0] r_seg_q;

    // read stage and output register
    logic                r_s2_valid;
    logic                r_s2_done;
    logic [LENGTH_W-1:0] r_s2_len;
    logic                r_s2_ovf;
    logic                r_s2_rdok;
    logic                r_s2_bank;
    logic                r_out_valid;
    logic                r_out_done;
    logic [LENGTH_W-1:0] r_out_len;
    logic [7:0]          r_out_byte;
    logic                r_out_ovf;

    // combinational
    logic                s2_adv, in_acc, is_push, is_read;
    logic [LEN_W-1:0]    b_len;
    logic [CNT_W-1:0]    b_cnt;
    logic [SEGLEN_W-1:0] b_seg;
    logic [1:0]          b_flags;
    logic                full, opening, closing, one_dot, two_dots;
    logic [LEN_W-1:0]    top_eff;
    logic                pw_en   [2];
    logic [BANK_AW-1:0]  pw_addr [2];
    logic [7:0]          pw_data [2];
    logic                seg_we;
    logic [SEG_AW-1:0]   seg_wa;
    logic [SEG_AW-1:0]   seg_ra;
    logic                rd_ok;
    logic [ADDR_W-1:0]   rd_index;

    assign s2_adv     = r_s2_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s2_valid || s2_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_push    = in_acc && (i_op == OP_PUSH);
    assign is_read    = in_acc && (i_op == OP_READ);
    assign top_eff    = r_rd_pend ? r_seg_q : r_top_start;
    assign rd_index   = ADDR_W'(i_index);
    assign rd_ok      = LEN_W'(i_index) < r_path_len;

    always_comb begin
        b_len        = r_finished ? '0 : r_path_len;
        b_cnt        = r_finished ? '0 : r_cnt;
        b_seg        = r_finished ? '0 : r_seg_len;
        b_flags      = r_finished ? '0 : r_flags;
        n_path_len   = r_path_len;
        n_cnt        = r_cnt;
        n_seg_len    = r_seg_len;
        n_flags      = r_flags;
        n_ovf        = r_ovf;
        n_finished   = r_finished;
        n_open_start = r_open_start;
        n_top_start  = top_eff;
        n_rd_pend    = 1'b0;
        full         = b_cnt >= CNT_W'(MAX_SEGMENTS);
        opening      = 1'b0;
        closing      = 1'b0;
        one_dot      = 1'b0;
        two_dots     = 1'b0;
        seg_we       = 1'b0;
        seg_wa       = b_cnt[SEG_AW-1:0];
        seg_ra       = SEG_AW'(b_cnt - CNT_W'(2));
        for (int k = 0; k < 2; k++) begin
            pw_en[k]   = 1'b0;
            pw_addr[k] = '0;
            pw_data[k] = '0;
        end

        if (is_push) begin
            n_path_len = b_len;
            n_cnt      = b_cnt;
            n_seg_len  = b_seg;
            n_flags    = b_flags;
            n_ovf      = r_finished ? 1'b0 : r_ovf;
            n_finished = 1'b0;

            if (i_ch == CH_SLASH) begin
                closing = b_seg != '0;
            end else begin
                opening = (b_seg == '0) && !full;
                if (opening) begin
                    seg_we       = 1'b1;
                    n_open_start = n_path_len;
                    if (n_path_len < LEN_W'(PATH_BYTES)) begin
                        pw_en[n_path_len[0]]   = 1'b1;
                        pw_addr[n_path_len[0]] = n_path_len[ADDR_W-1:1];
                        pw_data[n_path_len[0]] = CH_SLASH;
                        n_path_len             = n_path_len + LEN_W'(1);
                    end
                end
                if (!full && (n_path_len < LEN_W'(PATH_BYTES))) begin
                    pw_en[n_path_len[0]]   = 1'b1;
                    pw_addr[n_path_len[0]] = n_path_len[ADDR_W-1:1];
                    pw_data[n_path_len[0]] = i_ch;
                    n_path_len             = n_path_len + LEN_W'(1);
                end
                if (i_ch == CH_DOT) begin
                    if (b_seg == SEGLEN_W'(0)) begin
                        n_flags[0] = 1'b1;
                    end else if (b_seg == SEGLEN_W'(1)) begin
                        n_flags[1] = 1'b1;
                    end
                end
                if (b_seg <= SEGLEN_W'(PATH_BYTES)) begin
                    n_seg_len = b_seg + SEGLEN_W'(1);
                end
                closing = i_last;
            end

            if (closing) begin
                one_dot  = (n_seg_len == SEGLEN_W'(1)) && n_flags[0];
                two_dots = (n_seg_len == SEGLEN_W'(2)) && (n_flags == 2'b11);
                if (one_dot) begin
                    if (!full) begin
                        n_path_len = n_open_start;
                    end
                end else if (two_dots) begin
                    if (!full) begin
                        n_path_len = n_open_start;
                    end
                    if (b_cnt != '0) begin
                        n_cnt      = b_cnt - CNT_W'(1);
                        n_path_len = top_eff;
                        n_rd_pend  = b_cnt >= CNT_W'(2);
                    end
                end else if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    if (SUM_W'(n_open_start) + SUM_W'(n_seg_len) + SUM_W'(1)
                            > SUM_W'(PATH_BYTES)) begin
                        n_ovf = 1'b1;
                    end
                    n_cnt       = b_cnt + CNT_W'(1);
                    n_top_start = n_open_start;
                end
                n_seg_len = '0;
                n_flags   = '0;
            end

            if (i_last) begin
                if (n_path_len == '0) begin
                    // empty result becomes the root; other writes lie beyond it
                    pw_en[0]   = 1'b1;
                    pw_addr[0] = '0;
                    pw_data[0] = CH_SLASH;
                    pw_en[1]   = 1'b0;
                    n_path_len = LEN_W'(1);
                end
                n_finished = 1'b1;
            end
        end
    end

    // path store banks and segment stack
    always_ff @(posedge i_clk) begin
        if (pw_en[0]) begin
            r_bank_even[pw_addr[0]] <= pw_data[0];
        end
        if (pw_en[1]) begin
            r_bank_odd[pw_addr[1]] <= pw_data[1];
        end
        if (is_read) begin
            r_bank_even_q <= r_bank_even[rd_index[ADDR_W-1:1]];
            r_bank_odd_q  <= r_bank_odd[rd_index[ADDR_W-1:1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            r_seg_mem[seg_wa] <= n_open_start;
        end
        if (n_rd_pend) begin
            r_seg_q <= r_seg_mem[seg_ra];
        end
    end

    // state, read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len  <= '0;
            r_cnt       <= '0;
            r_seg_len   <= '0;
            r_flags     <= '0;
            r_ovf       <= 1'b0;
            r_finished  <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_path_len <= n_path_len;
            r_cnt      <= n_cnt;
            r_seg_len  <= n_seg_len;
            r_flags    <= n_flags;
            r_ovf      <= n_ovf;
            r_finished <= n_finished;
            r_rd_pend  <= n_rd_pend;
            if (in_acc) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_open_start <= n_open_start;
        r_top_start  <= n_top_start;
        if (in_acc) begin
            r_s2_done <= n_finished;
            r_s2_len  <= n_finished ? LENGTH_W'(n_path_len) : '0;
            r_s2_ovf  <= n_ovf;
            r_s2_rdok <= is_read && rd_ok;
            r_s2_bank <= rd_index[0];
        end
        if (s2_adv) begin
            r_out_done <= r_s2_done;
            r_out_len  <= r_s2_len;
            r_out_ovf  <= r_s2_ovf;
            r_out_byte <= r_s2_rdok ? (r_s2_bank ? r_bank_odd_q : r_bank_even_q) : 8'h00;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_done_res  = r_out_done;
    assign o_length    = r_out_len;
    assign o_byte_out  = r_out_byte;
    assign o_overflow  = r_out_ovf;

endmodule

// File: rtl/core/upc_checker.sv
// ----------------------------------------------------------------------------
// upc_checker
// Port-level checks for the unix path canonicaliser, bound to the top level.
// ----------------------------------------------------------------------------
module upc_checker
    import upc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_done_res,
    input logic [LENGTH_W-1:0] o_length,
    input logic [7:0]          o_byte_out,
    input logic                o_overflow
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_length)
            && $stable(o_byte_out) && $stable(o_done_res) && $stable(o_overflow)))
        else $error("stalled result changed");

    // a finished path has at least the root
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_length != '0))
        else $error("finished path with zero length");

    // length only shown once the path is finished
    a_open_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_length == '0))
        else $error("length shown for an unfinished path");

    // length within store capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_length <= LENGTH_W'(PATH_BYTES)))
        else $error("length beyond capacity");

endmodule

bind unix_path_canonicalizer_core upc_checker u_upc_checker (.*);

// File: tb/upc_canon_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_canon_checker
// Watches both channels of the path canonicaliser. Every input transfer is
// run through a cycle-free model of the canonical path store, and the result
// it gives is queued. Every result transfer is compared field by field with
// the oldest queued result. Failures and the queue depth go to the top level.
// ----------------------------------------------------------------------------
module upc_canon_checker
    import upc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_op,
    input  logic [7:0]          i_ch,
    input  logic                i_last,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_done_res,
    input  logic [LENGTH_W-1:0] i_length,
    input  logic [7:0]          i_byte_out,
    input  logic                i_overflow,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic                done_res;
        logic [LENGTH_W-1:0] length;
        logic [7:0]          byte_out;
        logic                overflow;
    } t_canon_result;

    logic [7:0]          canon_mem [PATH_BYTES];
    logic [LEN_W-1:0]    canon_len;
    logic [LEN_W-1:0]    seg_start_stack [MAX_SEGMENTS];
    logic [CNT_W-1:0]    seg_depth;
    logic [SEGLEN_W-1:0] open_seg_len;
    logic [1:0]          dot_marks;
    logic                sticky_ovf;
    logic                path_done;

    t_canon_result       canon_expect_q [$];

    function automatic void clear_path();
        canon_len    = '0;
        seg_depth    = '0;
        open_seg_len = '0;
        dot_marks    = '0;
        sticky_ovf   = 1'b0;
        path_done    = 1'b0;
    endfunction

    function automatic void store_byte(input logic [7:0] b);
        if (canon_len < PATH_BYTES) begin
            canon_mem[canon_len[ADDR_W-1:0]] = b;
            canon_len = canon_len + 1'b1;
        end
    endfunction

    function automatic void seal_segment();
        logic stack_full;
        logic lone_dot;
        logic double_dot;
        stack_full = seg_depth >= MAX_SEGMENTS;
        lone_dot   = open_seg_len == 1 && dot_marks[0];
        double_dot = open_seg_len == 2 && dot_marks == 2'b11;
        if (lone_dot) begin
            if (!stack_full)
                canon_len = seg_start_stack[seg_depth[SEG_AW-1:0]];
        end else if (double_dot) begin
            if (!stack_full)
                canon_len = seg_start_stack[seg_depth[SEG_AW-1:0]];
            if (seg_depth > 0) begin
                seg_depth = seg_depth - 1'b1;
                canon_len = seg_start_stack[seg_depth[SEG_AW-1:0]];
            end
        end else if (stack_full) begin
            sticky_ovf = 1'b1;
        end else begin
            if (int'(seg_start_stack[seg_depth[SEG_AW-1:0]]) + 1 + int'(open_seg_len)
                    > PATH_BYTES)
                sticky_ovf = 1'b1;
            seg_depth = seg_depth + 1'b1;
        end
        open_seg_len = '0;
        dot_marks    = '0;
    endfunction

    function automatic t_canon_result predict_canon(input logic op, input logic [7:0] ch,
                                                    input logic last,
                                                    input logic [INDEX_W-1:0] idx);
        t_canon_result r;
        logic          stack_full;
        r.byte_out = '0;
        if (op == OP_READ) begin
            if (idx < canon_len)
                r.byte_out = canon_mem[idx];
        end else begin
            if (path_done)
                clear_path();
            if (ch == CH_SLASH) begin
                if (open_seg_len > 0)
                    seal_segment();
            end else begin
                stack_full = seg_depth >= MAX_SEGMENTS;
                if (open_seg_len == 0 && !stack_full) begin
                    seg_start_stack[seg_depth[SEG_AW-1:0]] = canon_len;
                    store_byte(CH_SLASH);
                end
                if (!stack_full)
                    store_byte(ch);
                if (ch == CH_DOT) begin
                    if (open_seg_len == 0)
                        dot_marks[0] = 1'b1;
                    else if (open_seg_len == 1)
                        dot_marks[1] = 1'b1;
                end
                if (open_seg_len <= PATH_BYTES)
                    open_seg_len = open_seg_len + 1'b1;
            end
            if (last) begin
                if (open_seg_len > 0)
                    seal_segment();
                if (canon_len == 0) begin
                    canon_mem[0] = CH_SLASH;
                    canon_len    = LEN_W'(1);
                end
                path_done = 1'b1;
            end
        end
        r.done_res = path_done;
        r.length   = path_done ? canon_len : '0;
        r.overflow = sticky_ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_canon_result want;
        if (!i_rst_n) begin
            clear_path();
            canon_expect_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                canon_expect_q.push_back(predict_canon(i_op, i_ch, i_last, i_index));
            if (i_out_valid && i_out_ready) begin
                if (canon_expect_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result transfer with nothing expected", $time);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = canon_expect_q.pop_front();
                    if (want.done_res !== i_done_res || want.length !== i_length ||
                            want.byte_out !== i_byte_out || want.overflow !== i_overflow) begin
                        if (o_fail_count < 10)
                            $display({"%0t: mismatch, expected done %0d len %0d byte %02h ",
                                      "ovf %0d, got done %0d len %0d byte %02h ovf %0d"},
                                     $time, want.done_res, want.length, want.byte_out,
                                     want.overflow, i_done_res, i_length, i_byte_out,
                                     i_overflow);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= canon_expect_q.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the path canonicaliser core. A short directed run
// covers the root cases, dot segments and reads, then random paths, noise and
// two long paths fill the segment stack and the byte store. Both channels
// idle at random; a separate checker predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tb
    import upc_pkg::*;
;

    localparam int RUN_ITEMS  = 1975;
    localparam int HOLD_START = 900;
    localparam int HOLD_LEN   = 400;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_op        = OP_PUSH;
    logic [7:0]          i_ch        = '0;
    logic                i_last      = 1'b0;
    logic [INDEX_W-1:0]  i_index     = '0;
    logic                i_out_ready = 1'b0;
    logic                rx_hold     = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_done_res;
    logic [LENGTH_W-1:0] o_length;
    logic [7:0]          o_byte_out;
    logic                o_overflow;
    int                  canon_fails;
    int                  canon_pending;
    int                  items_sent = 0;
    int                  tx_burst   = 0;

    always #5 i_clk = ~i_clk;

    unix_path_canonicalizer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_done_res  (o_done_res),
        .o_length    (o_length),
        .o_byte_out  (o_byte_out),
        .o_overflow  (o_overflow)
    );

    upc_canon_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .i_index      (i_index),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_done_res   (o_done_res),
        .i_length     (o_length),
        .i_byte_out   (o_byte_out),
        .i_overflow   (o_overflow),
        .o_fail_count (canon_fails),
        .o_pending    (canon_pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_SLASH || c == CH_DOT);
        return c;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] ch, input logic last,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        if (tx_burst > 0) begin
            tx_burst--;
            gap = 0;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 59) == 0)
                tx_burst = $urandom_range(40, 160);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_ch       <= ch;
        i_last     <= last;
        i_index    <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last);
        send_item(OP_PUSH, ch, last, INDEX_W'($urandom_range(0, PATH_BYTES - 1)));
    endtask

    task automatic read_at(input int idx);
        send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  INDEX_W'(idx));
    endtask

    task automatic push_text(input string s, input logic end_path);
        int n;
        for (n = 0; n < s.len(); n++)
            push_char(s[n], end_path && n == s.len() - 1);
    endtask

    // receiver side idling
    initial begin : rx_side
        int gap_left;
        int burst_left;
        gap_left   = 0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (gap_left > 0) begin
                gap_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !rx_hold;
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 49) == 0)
                    burst_left = $urandom_range(40, 160);
                else
                    gap_left = idle_len();
            end
        end
    end

    // long receiver hold-off so the core backs up and stalls its input
    initial begin : rx_hold_ctl
        int n;
        repeat (12 + HOLD_START) @(posedge i_clk);
        rx_hold <= 1'b1;
        for (n = 0; n < HOLD_LEN; n++)
            @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : timeout
        #9_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] path_q [$];
        logic       stack_fill_done;
        logic       store_fill_done;
        int         nseg;
        int         s;
        int         k;
        int         fill;
        int         seg;
        stack_fill_done = 1'b0;
        store_fill_done = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // root cases, dot segments, byte extremes, reads in and out of range
        read_at(0);
        push_text("/", 1'b1);
        read_at(0);
        read_at(PATH_BYTES - 1);
        push_text("../x", 1'b0);
        read_at(1);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_text("/./../.", 1'b1);
        push_text("a../", 1'b1);
        read_at(3);
        push_text("...", 1'b1);

        // sender pause until every result has come back
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (canon_pending != 0);

        while (items_sent < RUN_ITEMS) begin
            if (!stack_fill_done && items_sent > 300) begin
                // fill the segment stack exactly, then push past it
                stack_fill_done = 1'b1;
                push_char(CH_SLASH, 1'b1);
                for (k = 0; k < MAX_SEGMENTS; k++) begin
                    push_char(plain_char(), 1'b0);
                    push_char(CH_SLASH, 1'b0);
                end
                read_at(PATH_BYTES - 1);
                push_char(plain_char(), 1'b0);
                push_char(plain_char(), 1'b0);
                push_text("/./../", 1'b0);
                read_at(PATH_BYTES - 2);
                push_text("..", 1'b1);
                read_at(PATH_BYTES - 5);
                read_at(PATH_BYTES - 4);
            end else if (!store_fill_done && items_sent > 1000) begin
                // long segments until the byte store runs out
                store_fill_done = 1'b1;
                push_char(CH_SLASH, 1'b1);
                fill = 0;
                while (fill < PATH_BYTES + 24) begin
                    seg = $urandom_range(40, 90);
                    repeat (seg) push_char(plain_char(), 1'b0);
                    push_char(CH_SLASH, 1'b0);
                    fill += seg + 1;
                end
                read_at(PATH_BYTES - 1);
                push_text("./../", 1'b0);
                push_char(plain_char(), 1'b0);
                push_text("/..", 1'b1);
                read_at($urandom_range(0, PATH_BYTES - 1));
            end else if ($urandom_range(0, 3) != 0) begin
                // well-formed path with random segments
                path_q.delete();
                if ($urandom_range(0, 3) != 0)
                    path_q.push_back(CH_SLASH);
                nseg = $urandom_range(0, 6);
                for (s = 0; s < nseg; s++) begin
                    case ($urandom_range(0, 9))
                        0, 1: path_q.push_back(CH_DOT);
                        2, 3: begin
                            path_q.push_back(CH_DOT);
                            path_q.push_back(CH_DOT);
                        end
                        4: begin
                            path_q.push_back(CH_DOT);
                            path_q.push_back($urandom_range(0, 1) ? CH_DOT : plain_char());
                            if ($urandom_range(0, 1))
                                path_q.push_back(CH_DOT);
                        end
                        default: begin
                            repeat ($urandom_range(1, 6))
                                path_q.push_back($urandom_range(0, 4) == 0 ? CH_DOT
                                                                          : plain_char());
                        end
                    endcase
                    if (s < nseg - 1 || $urandom_range(0, 2) == 0)
                        repeat ($urandom_range(0, 5) == 0 ? $urandom_range(2, 3) : 1)
                            path_q.push_back(CH_SLASH);
                end
                if (path_q.size() == 0)
                    path_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_DOT);
                for (k = 0; k < path_q.size(); k++) begin
                    if ($urandom_range(0, 9) == 0)
                        read_at($urandom_range(0, 24));
                    push_char(path_q[k], k == path_q.size() - 1);
                end
                repeat ($urandom_range(0, 3))
                    read_at($urandom_range(0, 5) == 0 ? $urandom_range(0, PATH_BYTES - 1)
                                                     : $urandom_range(0, 24));
            end else begin
                // noise: any op, any byte, stray last flags
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom_range(0, 1)),
                              $urandom_range(0, 2) == 0 ? CH_SLASH :
                              $urandom_range(0, 3) == 0 ? CH_DOT :
                              8'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0,
                              INDEX_W'($urandom_range(0, PATH_BYTES - 1)));
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (canon_pending != 0);
        repeat (10) @(posedge i_clk);
        if (canon_fails == 0 && canon_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
